@@ design/b24rgb_pkg.sv @@
package b24rgb_pkg;

  // parser phases, one-hot
  typedef enum logic [3:0] {
    PH_HEADER     = 4'b0001,
    PH_HEADER_BAD = 4'b0010,
    PH_PIXELS     = 4'b0100,
    PH_IDLE       = 4'b1000
  } phase_t;

  // result kinds carried on out_tuser
  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_ORIGIN_X  = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y  = 2'd1;
  localparam logic [1:0] REG_DISP_W    = 2'd2;
  localparam logic [1:0] REG_DISP_H    = 2'd3;

  localparam int unsigned MAX_DIM_DEF = 4096;

  // header byte positions where a field completes
  localparam logic [31:0] HIDX_SIG    = 32'd1;
  localparam logic [31:0] HIDX_OFFSET = 32'd13;
  localparam logic [31:0] HIDX_WIDTH  = 32'd21;
  localparam logic [31:0] HIDX_HEIGHT = 32'd25;
  localparam logic [31:0] HIDX_PLANES = 32'd27;
  localparam logic [31:0] HIDX_DEPTH  = 32'd29;
  localparam logic [31:0] HIDX_COMPR  = 32'd33;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [15:0] BMP_PLANES    = 16'd1;
  localparam logic [15:0] BMP_DEPTH     = 16'd24;
  localparam logic [31:0] MIN_OFFSET    = 32'd34;

  localparam logic [12:0] DISP_LIMIT     = 13'd4096;
  localparam logic [12:0] DISP_W_DEFAULT = 13'd320;
  localparam logic [12:0] DISP_H_DEFAULT = 13'd240;

endpackage

@@ design/bmp24_stream_to_rgb565.sv @@
// bmp24_stream_to_rgb565: 24-bit BMP byte stream to RGB565 pixel stream
//
// input channel: one file byte per transaction on in_tdata, in file order;
// in_tuser high marks byte 0 of a new file and restarts the header parse.
// the 34-byte header is checked, then exactly one status transaction is
// sent (out_tuser = accepted or rejected). after acceptance the bytes up to
// the pixel offset are skipped, each BGR triple becomes one RGB565 pixel
// transaction with display coordinates, row padding is dropped, and pixels
// outside the display window are cropped. out_tlast flags the final visible
// pixel. all other bytes produce no output.
// throughput: one byte per cycle while in_tready is high, set by the single
// registered step that updates the parser counters and the result register together.
// reset (rst_n low, synchronous): config registers return to origin 0,0 and
// a 320x240 display; the parser expects header byte 0 next.
// stalls: results sit in an output register backed by a one-entry skid
// register; in_tready drops only once both are full.
// config writes (cfg_we) are expected only while no transaction is in flight.
module bmp24_stream_to_rgb565 #(
  parameter int unsigned MAX_DIM = b24rgb_pkg::MAX_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] file_byte
  input  logic        in_tuser,   // [0] start_of_file
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [11:0] pixel_x, [23:12] pixel_y, [39:24] color
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,  // last visible pixel
  // config write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [12:0] cfg_wdata
);
  import b24rgb_pkg::*;

  // config registers
  logic [11:0] origin_x_r, origin_y_r;
  logic [12:0] disp_w_r, disp_h_r;

  // parser state
  logic [31:0] byte_index_r, byte_index_nxt;
  phase_t      phase_r, phase_nxt;
  logic [31:0] hdr_shift_r, hdr_shift_nxt;
  logic [31:0] pix_offset_r, pix_offset_nxt;
  logic [12:0] img_w_r, img_w_nxt;
  logic [12:0] img_h_r, img_h_nxt;
  logic        top_down_r, top_down_nxt;
  logic [12:0] file_row_r, file_row_nxt;
  logic [12:0] col_r, col_nxt;       // pixel column within the file row
  logic [1:0]  sub_r, sub_nxt;       // byte within the BGR triple
  logic [1:0]  pad_r, pad_nxt;       // padding bytes seen at end of row
  logic [7:0]  blue_r, blue_nxt;
  logic [7:0]  green_r, green_nxt;

  // result of the current byte
  logic        res_valid;
  logic [1:0]  res_kind;
  logic [11:0] res_x, res_y;
  logic [15:0] res_color;
  logic        res_last;

  // output register and skid register
  logic        out_v_r, skid_v_r;
  logic [39:0] out_data_r, skid_data_r;
  logic [1:0]  out_kind_r, skid_kind_r;
  logic        out_last_r, skid_last_r;

  logic in_acc;
  logic push;

  assign in_tready  = ~skid_v_r;
  assign in_acc     = in_tvalid & in_tready;
  assign push       = in_acc & res_valid;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // header, skip and pixel step for one byte
  always_comb begin
    logic [31:0] cur_idx;
    phase_t      cur_phase;
    logic [31:0] cur_shift;
    logic        ok;
    logic [31:0] hmag;
    logic [12:0] dw, dh, px_sum, py_sum, drow, cw_a, ch_a, cw, ch, last_row;
    logic        row_end;

    cur_idx   = in_tuser ? 32'd0 : byte_index_r;
    cur_phase = in_tuser ? PH_HEADER : phase_r;
    cur_shift = in_tuser ? 32'd0 : hdr_shift_r;

    byte_index_nxt = (cur_idx != 32'hFFFF_FFFF) ? cur_idx + 32'd1 : cur_idx;
    phase_nxt      = cur_phase;
    hdr_shift_nxt  = cur_shift;
    pix_offset_nxt = pix_offset_r;
    img_w_nxt      = img_w_r;
    img_h_nxt      = img_h_r;
    top_down_nxt   = top_down_r;
    file_row_nxt   = file_row_r;
    col_nxt        = col_r;
    sub_nxt        = sub_r;
    pad_nxt        = pad_r;
    blue_nxt       = blue_r;
    green_nxt      = green_r;

    res_valid = 1'b0;
    res_kind  = KIND_PIXEL;
    res_x     = '0;
    res_y     = '0;
    res_color = '0;
    res_last  = 1'b0;

    ok      = (cur_phase == PH_HEADER);
    hmag    = '0;
    row_end = 1'b0;

    // window geometry, display sizes clamp at 4096
    dw       = (disp_w_r > DISP_LIMIT) ? DISP_LIMIT : disp_w_r;
    dh       = (disp_h_r > DISP_LIMIT) ? DISP_LIMIT : disp_h_r;
    drow     = top_down_r ? file_row_r : img_h_r - 13'd1 - file_row_r;
    px_sum   = {1'b0, origin_x_r} + col_r;
    py_sum   = {1'b0, origin_y_r} + drow;
    cw_a     = dw - {1'b0, origin_x_r};
    ch_a     = dh - {1'b0, origin_y_r};
    cw       = (cw_a < img_w_r) ? cw_a : img_w_r;
    ch       = (ch_a < img_h_r) ? ch_a : img_h_r;
    last_row = top_down_r ? ch - 13'd1 : img_h_r - 13'd1;

    case (cur_phase)
      PH_HEADER, PH_HEADER_BAD: begin
        hdr_shift_nxt = {in_tdata, cur_shift[31:8]};
        hmag = hdr_shift_nxt[31] ? (32'd0 - hdr_shift_nxt) : hdr_shift_nxt;
        case (cur_idx)
          HIDX_SIG: begin
            if (hdr_shift_nxt[31:16] != BMP_SIGNATURE) ok = 1'b0;
          end
          HIDX_OFFSET: begin
            pix_offset_nxt = hdr_shift_nxt;
            if (hdr_shift_nxt < MIN_OFFSET) ok = 1'b0;
          end
          HIDX_WIDTH: begin
            if (hdr_shift_nxt > 32'(MAX_DIM)) ok = 1'b0;
            else img_w_nxt = hdr_shift_nxt[12:0];
          end
          HIDX_HEIGHT: begin
            top_down_nxt = hdr_shift_nxt[31];
            if (hmag > 32'(MAX_DIM)) ok = 1'b0;
            else img_h_nxt = hmag[12:0];
          end
          HIDX_PLANES: begin
            if (hdr_shift_nxt[31:16] != BMP_PLANES) ok = 1'b0;
          end
          HIDX_DEPTH: begin
            if (hdr_shift_nxt[31:16] != BMP_DEPTH) ok = 1'b0;
          end
          default: ;
        endcase
        if (cur_idx == HIDX_COMPR) begin
          if (hdr_shift_nxt != 32'd0) ok = 1'b0;
          res_valid    = 1'b1;
          res_kind     = ok ? KIND_ACCEPT : KIND_REJECT;
          file_row_nxt = '0;
          col_nxt      = '0;
          sub_nxt      = '0;
          pad_nxt      = '0;
          phase_nxt    = (ok && img_w_r != 13'd0 && img_h_r != 13'd0) ? PH_PIXELS : PH_IDLE;
        end else begin
          phase_nxt = ok ? PH_HEADER : PH_HEADER_BAD;
        end
      end
      PH_PIXELS: begin
        if (cur_idx >= pix_offset_r) begin
          if (col_r < img_w_r) begin
            case (sub_r)
              2'd0: begin
                blue_nxt = in_tdata;
                sub_nxt  = 2'd1;
              end
              2'd1: begin
                green_nxt = in_tdata;
                sub_nxt   = 2'd2;
              end
              default: begin
                sub_nxt = 2'd0;
                col_nxt = col_r + 13'd1;
                row_end = (col_nxt == img_w_r) && (img_w_r[1:0] == 2'd0);
                if (px_sum < dw && py_sum < dh) begin
                  res_valid = 1'b1;
                  res_kind  = KIND_PIXEL;
                  res_x     = px_sum[11:0];
                  res_y     = py_sum[11:0];
                  res_color = {in_tdata[7:3], green_r[7:2], blue_r[7:3]};
                  res_last  = (col_r == cw - 13'd1) && (file_row_r == last_row);
                end
              end
            endcase
          end else begin
            // padding to a four-byte row: width mod 4 bytes
            pad_nxt = pad_r + 2'd1;
            row_end = (pad_nxt == img_w_r[1:0]);
          end
          if (row_end) begin
            col_nxt      = '0;
            sub_nxt      = '0;
            pad_nxt      = '0;
            file_row_nxt = file_row_r + 13'd1;
            if (file_row_nxt >= img_h_r) phase_nxt = PH_IDLE;
          end
        end
      end
      default: ;
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      disp_w_r   <= DISP_W_DEFAULT;
      disp_h_r   <= DISP_H_DEFAULT;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ORIGIN_X: origin_x_r <= cfg_wdata[11:0];
        REG_ORIGIN_Y: origin_y_r <= cfg_wdata[11:0];
        REG_DISP_W:   disp_w_r   <= cfg_wdata;
        REG_DISP_H:   disp_h_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= '0;
      phase_r      <= PH_HEADER;
      hdr_shift_r  <= '0;
      pix_offset_r <= '0;
      img_w_r      <= '0;
      img_h_r      <= '0;
      top_down_r   <= 1'b0;
      file_row_r   <= '0;
      col_r        <= '0;
      sub_r        <= '0;
      pad_r        <= '0;
      blue_r       <= '0;
      green_r      <= '0;
    end else if (in_acc) begin
      byte_index_r <= byte_index_nxt;
      phase_r      <= phase_nxt;
      hdr_shift_r  <= hdr_shift_nxt;
      pix_offset_r <= pix_offset_nxt;
      img_w_r      <= img_w_nxt;
      img_h_r      <= img_h_nxt;
      top_down_r   <= top_down_nxt;
      file_row_r   <= file_row_nxt;
      col_r        <= col_nxt;
      sub_r        <= sub_nxt;
      pad_r        <= pad_nxt;
      blue_r       <= blue_nxt;
      green_r      <= green_nxt;
    end
  end

  // output register with skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      // skid full implies in_tready low, so no new push here
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_data_r <= skid_data_r;
        out_kind_r <= skid_kind_r;
        out_last_r <= skid_last_r;
      end else if (push) begin
        out_data_r <= {res_color, res_y, res_x};
        out_kind_r <= res_kind;
        out_last_r <= res_last;
      end
    end else if (push) begin
      skid_data_r <= {res_color, res_y, res_x};
      skid_kind_r <= res_kind;
      skid_last_r <= res_last;
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import b24rgb_pkg::*;

  localparam int unsigned MAX_DIM        = MAX_DIM_DEF;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          RANDOM_BYTES   = 200;

  // one output transaction as the decoder presents it
  typedef struct {
    logic [1:0]  kind;
    logic [11:0] x;
    logic [11:0] y;
    logic [15:0] color;
    logic        last;
  } bmp_result_t;

  // the header fields a file carries, before little-endian packing
  typedef struct {
    logic [15:0] sig;
    logic [31:0] offset;
    logic [31:0] width;
    logic [31:0] height;
    logic [15:0] planes;
    logic [15:0] depth;
    logic [31:0] compr;
  } bmp_hdr_t;

  // shadow copy of the decoder: parser state, registers and the results still owed
  class bmp_decode_shadow;
    phase_t      phase;
    logic [31:0] byte_idx;
    logic [31:0] hdr_word;
    logic [31:0] pix_off;
    int unsigned img_w;
    int unsigned img_h;
    bit          top_down;
    int unsigned file_row;
    int unsigned row_pos;
    logic [7:0]  blue_b;
    logic [7:0]  green_b;
    logic [11:0] org_x;
    logic [11:0] org_y;
    logic [12:0] disp_w;
    logic [12:0] disp_h;
    bmp_result_t due[$];
    int          errors;
    int          n_pixels;
    int          n_accept;
    int          n_reject;

    function new();
      phase    = PH_HEADER;
      byte_idx = '0;
      hdr_word = '0;
      pix_off  = '0;
      img_w    = 0;
      img_h    = 0;
      top_down = 0;
      file_row = 0;
      row_pos  = 0;
      blue_b   = '0;
      green_b  = '0;
      org_x    = '0;
      org_y    = '0;
      disp_w   = DISP_W_DEFAULT;
      disp_h   = DISP_H_DEFAULT;
      errors   = 0;
      n_pixels = 0;
      n_accept = 0;
      n_reject = 0;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void write_reg(logic [1:0] addr, logic [12:0] value);
      case (addr)
        REG_ORIGIN_X: org_x = value[11:0];
        REG_ORIGIN_Y: org_y = value[11:0];
        REG_DISP_W:   disp_w = value;
        REG_DISP_H:   disp_h = value;
        default: ;
      endcase
    endfunction

    // header bytes: shift in, check each field as its last byte lands
    function void header_byte(logic [31:0] idx, logic [7:0] b);
      bit          ok;
      logic [31:0] h;
      bmp_result_t r;
      ok = (phase == PH_HEADER);
      hdr_word = {b, hdr_word[31:8]};
      case (idx)
        HIDX_SIG:    if (hdr_word[31:16] != BMP_SIGNATURE) ok = 0;
        HIDX_OFFSET: begin
          pix_off = hdr_word;
          if (pix_off < MIN_OFFSET) ok = 0;
        end
        HIDX_WIDTH: begin
          if (hdr_word > MAX_DIM) ok = 0;
          else img_w = hdr_word;
        end
        HIDX_HEIGHT: begin
          h = hdr_word;
          top_down = h[31];
          if (top_down) h = 32'd0 - h;
          if (h > MAX_DIM) ok = 0;
          else img_h = h;
        end
        HIDX_PLANES: if (hdr_word[31:16] != BMP_PLANES) ok = 0;
        HIDX_DEPTH:  if (hdr_word[31:16] != BMP_DEPTH) ok = 0;
        HIDX_COMPR: begin
          if (hdr_word != 32'd0) ok = 0;
          r = '{ok ? KIND_ACCEPT : KIND_REJECT, 12'd0, 12'd0, 16'd0, 1'b0};
          due.push_back(r);
          file_row = 0;
          row_pos  = 0;
          phase = (ok && img_w != 0 && img_h != 0) ? PH_PIXELS : PH_IDLE;
          return;
        end
        default: ;
      endcase
      phase = ok ? PH_HEADER : PH_HEADER_BAD;
    endfunction

    // pixel bytes: collect B, G, then emit on R if inside the display window
    function void pixel_byte(logic [7:0] b);
      int unsigned row_bytes, col, sub, dw, dh, drow, cw, ch, last_row;
      bmp_result_t r;
      row_bytes = (img_w * 3 + 3) & ~32'd3;
      if (row_pos < img_w * 3) begin
        col = row_pos / 3;
        sub = row_pos % 3;
        if (sub == 0) blue_b = b;
        else if (sub == 1) green_b = b;
        else begin
          dw   = 32'((disp_w > DISP_LIMIT) ? DISP_LIMIT : disp_w);
          dh   = 32'((disp_h > DISP_LIMIT) ? DISP_LIMIT : disp_h);
          drow = top_down ? file_row : img_h - 1 - file_row;
          if (org_x + col < dw && org_y + drow < dh) begin
            cw = (dw - org_x < img_w) ? dw - org_x : img_w;
            ch = (dh - org_y < img_h) ? dh - org_y : img_h;
            last_row = top_down ? ch - 1 : img_h - 1;
            r.kind  = KIND_PIXEL;
            r.x     = 12'(org_x + col);
            r.y     = 12'(org_y + drow);
            r.color = {b[7:3], green_b[7:2], blue_b[7:3]};
            r.last  = (col == cw - 1 && file_row == last_row);
            due.push_back(r);
          end
        end
      end
      row_pos++;
      if (row_pos >= row_bytes) begin
        row_pos = 0;
        file_row++;
        if (file_row >= img_h) phase = PH_IDLE;
      end
    endfunction

    // called for every accepted input transaction
    function void note_byte(logic mark, logic [7:0] b);
      logic [31:0] idx;
      if (mark) begin
        byte_idx = '0;
        phase    = PH_HEADER;
        hdr_word = '0;
      end
      idx = byte_idx;
      if (byte_idx != 32'hFFFF_FFFF) byte_idx++;
      case (phase)
        PH_HEADER, PH_HEADER_BAD: header_byte(idx, b);
        PH_PIXELS: if (idx >= pix_off) pixel_byte(b);
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 20) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_result(bmp_result_t got);
      bmp_result_t e;
      if (due.size() == 0) begin
        report($sformatf("unexpected result kind=%0d x=%0d y=%0d color=%h last=%b",
                         got.kind, got.x, got.y, got.color, got.last));
      end else begin
        e = due.pop_front();
        if (got.kind !== e.kind || got.x !== e.x || got.y !== e.y ||
            got.color !== e.color || got.last !== e.last)
          report($sformatf("got kind=%0d x=%0d y=%0d color=%h last=%b, want %0d %0d %0d %h %b",
                           got.kind, got.x, got.y, got.color, got.last,
                           e.kind, e.x, e.y, e.color, e.last));
        case (e.kind)
          KIND_PIXEL:  n_pixels++;
          KIND_ACCEPT: n_accept++;
          default:     n_reject++;
        endcase
      end
    endtask

    task check_drained();
      if (due.size() != 0)
        report($sformatf("%0d results never arrived", due.size()));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [12:0] cfg_wdata;

  bmp_decode_shadow sb;

  int burst_left;
  int bytes_sent;
  int files_sent;
  int cfg_phases;
  int idle_cycles;
  int rx_left;
  bit rx_on;

  bmp24_stream_to_rgb565 u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] file_byte
    .in_tuser   (in_tuser),   // [0] start_of_file
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [11:0] pixel_x, [23:12] pixel_y, [39:24] color
    .out_tuser  (out_tuser),  // [1:0] kind
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // receiver: random runs of ready and stall, with occasional long free runs
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_on = ($urandom_range(0, 2) != 0);
      rx_left = (rx_on && $urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
    end
    rx_left--;
    out_tready <= rx_on;
  end

  // monitor both channels at the rising edge; the watchdog watches for progress
  always @(posedge clk) begin
    bmp_result_t seen;
    bit          moved;
    if (rst_n) begin
      moved = 0;
      if (in_tvalid && in_tready) begin
        sb.note_byte(in_tuser, in_tdata);
        moved = 1;
      end
      if (out_tvalid && out_tready) begin
        seen.kind  = out_tuser;
        seen.x     = out_tdata[11:0];
        seen.y     = out_tdata[23:12];
        seen.color = out_tdata[39:24];
        seen.last  = out_tlast;
        sb.check_result(seen);
        moved = 1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // one byte transaction; called at a falling edge and returns at one, with
  // in_tvalid still high so the next byte can follow back to back
  task automatic send_byte(input logic mark, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 10);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= mark;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  // stop sending and let everything owed come out before touching registers
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic put_reg(input logic [1:0] addr, input logic [12:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    sb.write_reg(addr, value);
    @(negedge clk);
  endtask

  task automatic configure(input logic [12:0] ox, input logic [12:0] oy,
                           input logic [12:0] dw, input logic [12:0] dh);
    put_reg(REG_ORIGIN_X, ox);
    put_reg(REG_ORIGIN_Y, oy);
    put_reg(REG_DISP_W, dw);
    put_reg(REG_DISP_H, dh);
    cfg_we <= 1'b0;
    cfg_phases++;
  endtask

  function automatic bmp_hdr_t plain_hdr(logic [31:0] w, logic [31:0] h, logic [31:0] off);
    bmp_hdr_t hd;
    hd.sig    = BMP_SIGNATURE;
    hd.offset = off;
    hd.width  = w;
    hd.height = h;
    hd.planes = BMP_PLANES;
    hd.depth  = BMP_DEPTH;
    hd.compr  = 32'd0;
    return hd;
  endfunction

  // header, gap up to the pixel offset and padded rows of random color;
  // a header that will be rejected gets only a few ignored bytes behind it;
  // cut > 0 truncates the file there, tail appends bytes past the image
  task automatic send_file(input bmp_hdr_t hd, input logic mark, input int cut,
                           input int tail);
    logic [271:0] hdr_bits;
    logic [7:0]   fb[$];
    logic [31:0]  hmag;
    int unsigned  skip, nbody;
    bit           good;
    // file size, reserved and info header size are don't-care for the decoder
    hdr_bits = {hd.compr, hd.depth, hd.planes, hd.height, hd.width,
                32'($urandom), hd.offset, 32'($urandom), 32'($urandom), hd.sig};
    for (int i = 0; i < 34; i++) fb.push_back(hdr_bits[8*i +: 8]);
    hmag  = hd.height[31] ? 32'd0 - hd.height : hd.height;
    good  = hd.sig == BMP_SIGNATURE && hd.offset >= MIN_OFFSET && hd.width <= MAX_DIM &&
            hmag <= MAX_DIM && hd.planes == BMP_PLANES && hd.depth == BMP_DEPTH &&
            hd.compr == 32'd0;
    skip  = (hd.offset >= MIN_OFFSET && hd.offset <= 300) ? hd.offset - MIN_OFFSET : 6;
    nbody = (hd.width <= 64 && hmag <= 64) ? ((hd.width * 3 + 3) & ~32'd3) * hmag : 12;
    if (!good) begin
      skip  = 0;
      nbody = 4;
    end
    repeat (skip + nbody) fb.push_back(8'($urandom));
    if (cut > 0) while (fb.size() > cut) void'(fb.pop_back());
    repeat (tail) fb.push_back(8'($urandom));
    foreach (fb[i]) send_byte(i == 0 ? mark : 1'b0, fb[i]);
    files_sent++;
  endtask

  function automatic logic [12:0] pick_origin();
    case ($urandom_range(0, 5))
      0:       return {1'($urandom), 12'd4095};
      1:       return 13'($urandom);
      default: return {1'($urandom), 12'($urandom_range(0, 4))};
    endcase
  endfunction

  function automatic logic [12:0] pick_size();
    case ($urandom_range(0, 7))
      0:       return 13'd0;
      1:       return DISP_LIMIT;
      2:       return 13'h1FFF;
      3:       return 13'($urandom);
      4:       return DISP_W_DEFAULT;
      default: return 13'($urandom_range(1, 8));
    endcase
  endfunction

  initial begin
    bmp_hdr_t    hd;
    int          pick, start_count;
    logic [31:0] w, h, off;

    sb = new();
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = REG_ORIGIN_X;
    cfg_wdata  = '0;
    burst_left = 0;
    bytes_sent = 0;
    files_sent = 0;
    cfg_phases = 0;
    idle_cycles = 0;
    rx_left    = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset display 320x240 at origin 0,0
    // first file has no start mark: after reset the parser is already at byte 0
    send_file(plain_hdr(2, 2, 54), 1'b0, 0, 0);
    // top-down at the minimum offset, trailing bytes after the image ignored
    send_file(plain_hdr(3, -32'sd2, 34), 1'b1, 0, 3);
    // bad signature and bad compression together: still one reject at the end
    hd = plain_hdr(1, 1, 54);
    hd.sig   = 16'h4D43;
    hd.compr = 32'd7;
    send_file(hd, 1'b1, 0, 0);
    send_file(plain_hdr(1, 1, 33), 1'b1, 0, 0);
    send_file(plain_hdr(4097, 1, 54), 1'b1, 0, 0);
    send_file(plain_hdr(32'hFFFF_FFFF, 1, 54), 1'b1, 0, 0);
    // largest sizes with the other dimension zero: accepted, no pixels
    send_file(plain_hdr(4096, 0, 34), 1'b1, 0, 0);
    send_file(plain_hdr(0, -32'sd4096, 34), 1'b1, 0, 0);
    // most negative height counts as too tall
    send_file(plain_hdr(1, 32'h8000_0000, 54), 1'b1, 0, 0);
    send_file(plain_hdr(1, -32'sd4097, 54), 1'b1, 0, 0);
    hd = plain_hdr(1, 1, 54);
    hd.planes = 16'd0;
    send_file(hd, 1'b1, 0, 0);
    hd = plain_hdr(1, 1, 54);
    hd.depth = 16'h0118;
    send_file(hd, 1'b1, 0, 0);
    hd = plain_hdr(1, 1, 54);
    hd.compr = 32'h0100_0000;
    send_file(hd, 1'b1, 0, 0);
    // huge offset: accepted, every following byte is skipped
    send_file(plain_hdr(2, 2, 32'hFFFF_FFFF), 1'b1, 0, 0);
    // restart in the middle of a header and in the middle of pixel data
    send_file(plain_hdr(2, 2, 54), 1'b1, 10, 0);
    send_file(plain_hdr(4, 3, 40), 1'b1, 50, 0);
    send_file(plain_hdr(2, 1, 34), 1'b1, 0, 0);

    // origin at the far corner of a full-size display: only one pixel shows
    wait_idle();
    configure(13'h1FFF, 13'd4095, DISP_LIMIT, DISP_LIMIT);
    send_file(plain_hdr(3, -32'sd3, 34), 1'b1, 0, 0);
    send_file(plain_hdr(3, 3, 34), 1'b1, 0, 0);
    // zero-sized display shows nothing but the status
    wait_idle();
    configure(13'd0, 13'd0, 13'd0, 13'd0);
    send_file(plain_hdr(2, 2, 34), 1'b1, 0, 0);
    // oversized display registers behave as the limit
    wait_idle();
    configure(13'd0, 13'd0, 13'h1FFF, 13'h1FFF);
    send_file(plain_hdr(5, -32'sd2, 34), 1'b1, 0, 0);
    // small window crops both edges
    wait_idle();
    configure(13'd1, 13'd1, 13'd3, 13'd3);
    send_file(plain_hdr(4, 3, 34), 1'b1, 0, 0);
    send_file(plain_hdr(4, -32'sd3, 34), 1'b1, 0, 0);
    // image placed right of the display
    wait_idle();
    configure(13'd4095, 13'd0, DISP_W_DEFAULT, DISP_H_DEFAULT);
    send_file(plain_hdr(2, 2, 34), 1'b1, 0, 0);

    // random: mostly well-formed small images, some broken headers and noise
    start_count = bytes_sent;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        configure(pick_origin(), pick_origin(), pick_size(), pick_size());
      end
      w   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 7);
      h   = $urandom_range(0, 5);
      if ($urandom_range(0, 1) == 0) h = 32'd0 - h;
      off = ($urandom_range(0, 2) == 0) ? 54 : $urandom_range(34, 60);
      hd  = plain_hdr(w, h, off);
      pick = $urandom_range(0, 19);
      if (pick >= 14 && pick <= 16) begin
        case ($urandom_range(0, 6))
          0: hd.sig    = 16'($urandom);
          1: hd.offset = $urandom_range(0, 33);
          2: hd.width  = $urandom | 32'h0000_1001;
          3: hd.height = ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : $urandom;
          4: hd.planes = 16'($urandom);
          5: hd.depth  = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                     : (BMP_DEPTH | 16'h0100);
          default: hd.compr = $urandom | 32'd1;
        endcase
      end
      if (pick >= 18) begin
        repeat ($urandom_range(5, 40))
          send_byte($urandom_range(0, 7) == 0, 8'($urandom));
      end else begin
        send_file(hd, $urandom_range(0, 19) != 0,
                  (pick == 17) ? $urandom_range(10, 60) : 0,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
      end
    end

    wait_idle();
    repeat (10) @(negedge clk);
    sb.check_drained();
    $display("streamed %0d files, %0d bytes, under %0d register settings",
             files_sent, bytes_sent, cfg_phases + 1);
    $display("checked %0d pixels, %0d accepted and %0d rejected headers, %0d errors",
             sb.n_pixels, sb.n_accept, sb.n_reject, sb.errors);
    if (sb.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
design/b24rgb_pkg.sv
design/bmp24_stream_to_rgb565.sv
tb/tb.sv
